### rtl/core/lcd_gram_window_writer_core_macros.svh
// assertion helpers for the bound checker
`ifndef LCD_GRAM_WINDOW_WRITER_CORE_MACROS_SVH
`define LCD_GRAM_WINDOW_WRITER_CORE_MACROS_SVH

// clocked check, off while reset is asserted
`define LCDGWW_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");

// clocked check, also active through reset
`define LCDGWW_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("%m: check failed");

`endif

### rtl/core/lcdgww_pkg.sv
package lcdgww_pkg;

	localparam int unsigned PanelWidth       = 176;
	localparam int unsigned PanelHeight      = 220;
	localparam int unsigned WindowRightReset = PanelWidth - 1;
	localparam int unsigned PanelPixels      = PanelWidth * PanelHeight;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

	localparam logic [7:0] REG_CURSOR_X   = 8'h20;
	localparam logic [7:0] REG_CURSOR_Y   = 8'h21;
	localparam logic [7:0] REG_PIXEL_DATA = 8'h22;
	localparam logic [7:0] REG_HWIN_END   = 8'h36;
	localparam logic [7:0] REG_HWIN_START = 8'h37;
	localparam logic [7:0] REG_VWIN_END   = 8'h38;
	localparam logic [7:0] REG_VWIN_START = 8'h39;

	typedef enum logic [2:0] {
		OP_WR_RIGHT,
		OP_WR_LEFT,
		OP_WR_CX,
		OP_WR_CY,
		OP_PIXEL
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] data;
	} op_entry_t;

endpackage

### rtl/core/lcdgww_front.sv
module lcdgww_front import lcdgww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_mode,
	input  logic [15:0] in_value,
	output logic        push,
	output op_entry_t   push_entry,
	input  logic        fifo_full
);

	logic [7:0] latched_reg_q;
	logic       pixel_mode_q;
	logic       accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_reg_q <= '0;
			pixel_mode_q  <= 1'b0;
		end else if (accept && !in_mode) begin
			latched_reg_q <= in_value[7:0];
			pixel_mode_q  <= (in_value[7:0] == REG_PIXEL_DATA);
		end
	end

	always_comb begin
		push            = 1'b0;
		push_entry.op   = OP_PIXEL;
		push_entry.data = in_value;
		if (accept && in_mode) begin
			if (pixel_mode_q) begin
				push = 1'b1;
			end else begin
				unique case (latched_reg_q)
					REG_HWIN_END: begin
						push          = 1'b1;
						push_entry.op = OP_WR_RIGHT;
					end
					REG_HWIN_START: begin
						push          = 1'b1;
						push_entry.op = OP_WR_LEFT;
					end
					REG_CURSOR_X: begin
						push          = 1'b1;
						push_entry.op = OP_WR_CX;
					end
					REG_CURSOR_Y: begin
						push          = 1'b1;
						push_entry.op = OP_WR_CY;
					end
					REG_VWIN_END, REG_VWIN_START: push = 1'b0;
					default: push = 1'b0;
				endcase
			end
		end
	end

endmodule

### rtl/core/lcdgww_fifo.sv
module lcdgww_fifo import lcdgww_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_entry_t push_entry,
	output logic      full,
	input  logic      pop,
	output op_entry_t pop_entry,
	output logic      empty
);

	op_entry_t             mem_q [FifoDepth];
	logic [FifoPtrW-1:0]   wr_ptr_q;
	logic [FifoPtrW-1:0]   rd_ptr_q;
	logic [FifoPtrW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (count_q == (FifoPtrW+1)'(FifoDepth));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= FifoPtrW'((FifoPtrW+1)'(wr_ptr_q) + 1'b1 == (FifoPtrW+1)'(FifoDepth)
					? 0 : wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= FifoPtrW'((FifoPtrW+1)'(rd_ptr_q) + 1'b1 == (FifoPtrW+1)'(FifoDepth)
					? 0 : rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/lcdgww_back.sv
module lcdgww_back import lcdgww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fifo_empty,
	input  op_entry_t   fifo_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_address,
	output logic [15:0] out_color
);

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] win_left_q;
	logic [15:0] win_right_q;
	logic        out_valid_q;
	logic [15:0] out_address_q;
	logic [15:0] out_color_q;

	logic        in_panel;
	logic [15:0] address;
	logic [15:0] next_x;
	logic        is_pixel;

	assign pop      = !fifo_empty && (!out_valid_q || out_ready);
	assign is_pixel = (fifo_entry.op == OP_PIXEL);
	assign in_panel = ({16'b0, cursor_x_q} < 32'(PanelWidth))
		&& ({16'b0, cursor_y_q} < 32'(PanelHeight));
	assign address  = cursor_y_q * 16'(PanelWidth) + cursor_x_q;
	assign next_x   = cursor_x_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			win_left_q  <= '0;
			win_right_q <= 16'(WindowRightReset);
		end else if (pop) begin
			unique case (fifo_entry.op)
				OP_WR_RIGHT: win_right_q <= fifo_entry.data;
				OP_WR_LEFT:  win_left_q  <= fifo_entry.data;
				OP_WR_CX:    cursor_x_q  <= fifo_entry.data;
				OP_WR_CY:    cursor_y_q  <= fifo_entry.data;
				OP_PIXEL: begin
					if (next_x > win_right_q) begin
						cursor_x_q <= win_left_q;
						cursor_y_q <= cursor_y_q + 16'd1;
					end else begin
						cursor_x_q <= next_x;
					end
				end
				default: cursor_x_q <= cursor_x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_pixel) begin
			out_valid_q <= in_panel;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_pixel && in_panel) begin
			out_address_q <= address;
			out_color_q   <= fifo_entry.data;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = out_address_q;
	assign out_color   = out_color_q;

endmodule

### rtl/core/lcd_gram_window_writer_core.sv
// Display GRAM window writer.
// Input stream: one transaction per bus item. tuser is the mode flag
// (0 = command byte in tdata[7:0], 1 = 16-bit data word in tdata).
// Command 0x22 enters pixel-write mode; any other command leaves it.
// Outside pixel-write mode data goes to window/cursor registers 0x36, 0x37,
// 0x20, 0x21; other registers swallow the data.
// Output stream: one transaction per on-panel pixel, tdata = {color, address},
// address = y * 176 + x. Off-panel pixels only advance the cursor.
// An accepted input item is written into the queue; the back end pops it and
// registers the output. Throughput: one item per cycle while the output is not
// stalled, set by the cursor update in the back end. A 4-entry queue between
// decode and execution absorbs output stalls; s_axis_tready drops only when it is full.
// Reset (arst_n low): cursor 0,0, window 0..175, register latch 0, pixel
// mode off, queue empty, no output pending.
module lcd_gram_window_writer_core import lcdgww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] value
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [15:0] pixel_address, [31:16] pixel_color
);

	logic      push;
	op_entry_t push_entry;
	logic      fifo_full;
	logic      pop;
	op_entry_t pop_entry;
	logic      fifo_empty;

	lcdgww_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (s_axis_tuser),
		.in_value   (s_axis_tdata),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (fifo_full)
	);

	lcdgww_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (fifo_empty)
	);

	lcdgww_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_entry  (pop_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_address (m_axis_tdata[15:0]),
		.out_color   (m_axis_tdata[31:16])
	);

endmodule

### rtl/core/lcdgww_checker.sv
`include "lcd_gram_window_writer_core_macros.svh"

module lcdgww_checker import lcdgww_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	localparam logic AddrWraps = (PanelPixels > 65536);

	// stalled output holds
	`LCDGWW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// addresses only for on-panel pixels
	`LCDGWW_ASSERT(a_addr_range, m_axis_tvalid |-> AddrWraps || ({16'b0, m_axis_tdata[15:0]} < 32'(PanelPixels)))

	// nothing leaves right out of reset
	`LCDGWW_ASSERT_ALWAYS(a_reset_quiet, !$past(arst_n) |-> !m_axis_tvalid)

	// a full queue only arises from accepted input
	`LCDGWW_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(s_axis_tvalid) && $past(s_axis_tuser))

endmodule

bind lcd_gram_window_writer_core lcdgww_checker u_lcdgww_checker (.*);

### tb/lcd_gram_window_writer_core_checker.sv
`timescale 1ns / 100ps

module lcd_gram_window_writer_core_checker import lcdgww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] value
	input  logic        s_axis_tuser,  // [0] mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // [15:0] pixel_address, [31:16] pixel_color
	output int unsigned errors,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [15:0] color;
		logic [15:0] addr;
	} pixel_store_t;

	pixel_store_t expected_stores[$];

	logic [7:0]  reg_sel;
	logic        pix_mode;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	logic [15:0] win_l;
	logic [15:0] win_r;
	int unsigned mismatch_count;

	task automatic note_mismatch(input string what, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s mismatch: expected 0x%04h, got 0x%04h", $time, what,
				exp_val, act_val);
		end
	endtask

	task automatic decode_bus_item(input logic mode, input logic [15:0] word);
		logic [31:0]  lin;
		pixel_store_t st;
		if (!mode) begin
			reg_sel  = word[7:0];
			pix_mode = (word[7:0] == REG_PIXEL_DATA);
		end else if (pix_mode) begin
			if (cur_x < PanelWidth && cur_y < PanelHeight) begin
				lin      = 32'(cur_y) * PanelWidth + 32'(cur_x);
				st.addr  = lin[15:0];
				st.color = word;
				expected_stores.push_back(st);
			end
			// auto increment inside the horizontal window
			cur_x = cur_x + 16'd1;
			if (cur_x > win_r) begin
				cur_x = win_l;
				cur_y = cur_y + 16'd1;
			end
		end else begin
			case (reg_sel)
				REG_HWIN_END:   win_r = word;
				REG_HWIN_START: win_l = word;
				REG_CURSOR_X:   cur_x = word;
				REG_CURSOR_Y:   cur_y = word;
				default: ;
			endcase
		end
	endtask

	task automatic compare_store(input logic [31:0] word);
		pixel_store_t st;
		if (expected_stores.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: unexpected store: addr 0x%04h color 0x%04h", $time,
					word[15:0], word[31:16]);
			end
		end else begin
			st = expected_stores.pop_front();
			if (word[15:0] !== st.addr) begin
				note_mismatch("pixel_address", st.addr, word[15:0]);
			end
			if (word[31:16] !== st.color) begin
				note_mismatch("pixel_color", st.color, word[31:16]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_sel  = 8'h00;
			pix_mode = 1'b0;
			cur_x    = 16'd0;
			cur_y    = 16'd0;
			win_l    = 16'd0;
			win_r    = 16'(WindowRightReset);
			expected_stores.delete();
			mismatch_count = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				compare_store(m_axis_tdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_bus_item(s_axis_tuser, s_axis_tdata);
			end
			errors      <= mismatch_count;
			outstanding <= expected_stores.size();
		end
	end

endmodule

### tb/lcd_gram_window_writer_core_tb.sv
`timescale 1ns / 100ps

module lcd_gram_window_writer_core_tb;
	import lcdgww_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned RandomItems = 900;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] value
	logic        s_axis_tuser;  // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // [15:0] pixel_address, [31:16] pixel_color

	int unsigned errors;
	int unsigned outstanding;
	int unsigned cycles;
	int unsigned items_sent;
	bit          quiet;

	lcd_gram_window_writer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	lcd_gram_window_writer_core_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 31);
	end

	task automatic send_item(input logic mode, input logic [15:0] word);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_cmd(input logic [7:0] r);
		send_item(1'b0, {8'($urandom), r});
	endtask

	task automatic send_data(input logic [15:0] w);
		send_item(1'b1, w);
	endtask

	task automatic wait_stores_done();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	// optional window setup, optional cursor setup, then a pixel burst
	task automatic send_frame();
		logic [15:0] l;
		logic [15:0] r;
		logic [15:0] x;
		logic [15:0] y;
		if ($urandom_range(2) == 0) begin
			case ($urandom_range(9))
				0: begin
					l = 16'($urandom);
					r = 16'($urandom);
				end
				1: begin
					l = 16'($urandom_range(175));
					r = 16'($urandom_range(65535, 176));
				end
				default: begin
					l = 16'($urandom_range(175));
					r = 16'($urandom_range(175, l));
				end
			endcase
			send_cmd(REG_HWIN_START);
			send_data(l);
			send_cmd(REG_HWIN_END);
			send_data(r);
		end
		if ($urandom_range(4) != 0) begin
			case ($urandom_range(9))
				0: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				1: begin
					x = 16'hFFFF - 16'($urandom_range(3));
					y = 16'($urandom_range(219));
				end
				2: begin
					x = 16'($urandom_range(175));
					y = 16'hFFFF - 16'($urandom_range(3));
				end
				default: begin
					x = 16'($urandom_range(175));
					y = 16'($urandom_range(219));
				end
			endcase
			send_cmd(REG_CURSOR_X);
			send_data(x);
			send_cmd(REG_CURSOR_Y);
			send_data(y);
		end
		send_cmd(REG_PIXEL_DATA);
		repeat ($urandom_range(24, 1)) send_data(16'($urandom));
	endtask

	task automatic send_noise();
		logic [7:0] r;
		if ($urandom_range(1) == 1) begin
			send_data(16'($urandom));
		end else begin
			case ($urandom_range(7))
				0: r = REG_CURSOR_X;
				1: r = REG_CURSOR_Y;
				2: r = REG_PIXEL_DATA;
				3: r = REG_HWIN_END;
				4: r = REG_HWIN_START;
				5: r = REG_VWIN_END;
				6: r = REG_VWIN_START;
				default: r = 8'($urandom);
			endcase
			send_cmd(r);
		end
	endtask

	initial begin
		int unsigned start;
		bit          paused;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = 16'h0000;
		quiet         = 1'b0;
		paused        = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// data with no register latched is dropped
		send_data(16'hFFFF);
		// upper command bits ignored
		send_item(1'b0, {8'hA5, REG_PIXEL_DATA});
		send_data(16'hFFFF);
		send_data(16'h0000);
		// last panel pixel, then step off the bottom edge
		send_cmd(REG_CURSOR_X);
		send_data(16'd175);
		send_cmd(REG_CURSOR_Y);
		send_data(16'd219);
		send_cmd(REG_PIXEL_DATA);
		send_data(16'h8001);
		send_data(16'h7FFE);
		// vertical window writes have no effect
		send_cmd(REG_VWIN_END);
		send_data(16'h1234);
		send_cmd(REG_VWIN_START);
		send_data(16'h5678);
		// left beyond right, cursor_y wrap from 0xFFFF
		send_cmd(REG_HWIN_START);
		send_data(16'd10);
		send_cmd(REG_HWIN_END);
		send_data(16'd5);
		send_cmd(REG_CURSOR_X);
		send_data(16'd5);
		send_cmd(REG_CURSOR_Y);
		send_data(16'hFFFF);
		send_cmd(REG_PIXEL_DATA);
		send_data(16'hAAAA);
		send_data(16'h5555);
		wait_stores_done();

		start = items_sent;
		while (items_sent < start + RandomItems) begin
			quiet = (items_sent > start + 300) && (items_sent < start + 450);
			if (!paused && items_sent >= start + 500) begin
				wait_stores_done();
				paused = 1'b1;
			end
			if ($urandom_range(3) != 0) begin
				send_frame();
			end else begin
				repeat ($urandom_range(4, 1)) send_noise();
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### lcd_gram_window_writer_core.f
+incdir+rtl/core
rtl/core/lcdgww_pkg.sv
rtl/core/lcdgww_front.sv
rtl/core/lcdgww_fifo.sv
rtl/core/lcdgww_back.sv
rtl/core/lcd_gram_window_writer_core.sv
rtl/core/lcdgww_checker.sv
tb/lcd_gram_window_writer_core_checker.sv
tb/lcd_gram_window_writer_core_tb.sv
